>>> sv/gif_signature_carver_unit_defines.svh
// assertion helpers for the gif signature carver
`ifndef GIF_SIGNATURE_CARVER_UNIT_DEFINES_SVH
`define GIF_SIGNATURE_CARVER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsc check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define GSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gsc check failed: next-cycle implication");

`endif

>>> sv/gsc_pkg.sv
package gsc_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int RUN_DEPTH  = 6;
    localparam int COUNT_W    = 20;
    localparam int FNUM_W     = 16;

    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] BYTE_LOW_A   = 8'h61;

    localparam logic [COUNT_W-1:0] MAX_SIZE_RESET = 20'd4000;
    localparam logic [COUNT_W-1:0] HEADER_LEN     = 20'd6;
    localparam logic [FNUM_W-1:0]  FIRST_FILE     = 16'd1;

    // expected history bytes, index 0 is the newest ("7" / "9", "8", "F", "I", "G")
    localparam logic [7:0] SIG_MAIN [HIST_DEPTH] = '{8'h37, 8'h38, 8'h46, 8'h49, 8'h47};
    localparam logic [7:0] SIG_ALT  [HIST_DEPTH] = '{8'h39, 8'h38, 8'h46, 8'h49, 8'h47};

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       file_end;
        logic       forced_end;
        logic       last;
    } t_slot;

endpackage

>>> sv/gsc_hist_cell.sv
module gsc_hist_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_shift,
    input  logic [7:0] i_din,
    input  logic [7:0] i_sig,
    input  logic [7:0] i_alt,
    output logic [7:0] o_dout,
    output logic       o_match
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_clear) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_din;
        end
    end

    assign o_dout  = r_byte;
    assign o_match = (r_byte == i_sig) || (r_byte == i_alt);

endmodule

>>> sv/gsc_run_cell.sv
module gsc_run_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  gsc_pkg::t_slot i_load_slot,
    input  logic           i_shift,
    input  gsc_pkg::t_slot i_next_slot,
    output gsc_pkg::t_slot o_slot
);

    gsc_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_load) begin
            r_slot <= i_load_slot;
        end else if (i_shift) begin
            r_slot <= i_next_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

>>> sv/gif_signature_carver_unit.sv
// gif signature carver: scans a raw byte stream for GIF87a / GIF89a headers
// and passes the bytes of each carved file out, tagged with its file number.
// input request: i_valid, i_data_byte, i_end_of_stream, taken when o_stall is low.
// output request: o_valid and the result fields, taken when i_stall is low.
// config: i_cfg_valid / o_cfg_ready write max_size, always ready; write it
// only while no results are pending.
// each accepted byte yields 0, 1, 3 or 6 results; they are loaded into a row of
// six run cells and shift out one per cycle while i_stall is low, the first in
// the cycle after accept. a byte giving one result can follow every cycle that
// i_stall is low; a byte giving several results holds the input until they drain,
// since the run cells drain at one result per output cycle. the next byte is
// taken in the cycle the last result of the current run leaves.
// a five-cell history chain shifts in each byte and compares against the header.
// reset (synchronous, active low) empties the run cells, clears history,
// stops carving, sets max_size to 4000 and the next file number to 1.
// while i_stall is high the output holds and the input stalls once a run is
// waiting, so nothing is dropped.
`include "gif_signature_carver_unit_defines.svh"

module gif_signature_carver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_file_number,
    output logic        o_file_end,
    output logic        o_forced_end,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_max_size
);

    localparam int HD = gsc_pkg::HIST_DEPTH;
    localparam int RD = gsc_pkg::RUN_DEPTH;

    logic [gsc_pkg::COUNT_W-1:0] r_max_size;
    logic [gsc_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [gsc_pkg::FNUM_W-1:0]  r_file_counter, n_file_counter;
    logic [gsc_pkg::FNUM_W-1:0]  r_file_number, n_file_number;
    logic                        r_carving, n_carving;

    logic       w_in_acc, w_out_acc;
    logic       w_hist_clear, w_hist_shift;
    logic [7:0] w_hist [HD];
    logic [HD-1:0] w_hist_match;
    logic       w_header;
    logic       w_trailer;
    logic       w_force;
    logic [gsc_pkg::COUNT_W-1:0] w_count_inc;

    gsc_pkg::t_slot w_load [RD];
    gsc_pkg::t_slot w_slot [RD];
    gsc_pkg::t_slot w_next [RD];

    assign o_cfg_ready = 1'b1;

    assign w_out_acc = o_valid && !i_stall;
    assign o_stall   = w_slot[0].valid && !(w_slot[0].last && !i_stall);
    assign w_in_acc  = i_valid && !o_stall;

    // history chain, cell 0 holds the newest byte
    for (genvar k = 0; k < HD; k++) begin : g_hist
        gsc_hist_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_hist_clear),
            .i_shift (w_hist_shift),
            .i_din   ((k == 0) ? i_data_byte : w_hist[(k == 0) ? 0 : k - 1]),
            .i_sig   (gsc_pkg::SIG_MAIN[k]),
            .i_alt   (gsc_pkg::SIG_ALT[k]),
            .o_dout  (w_hist[k]),
            .o_match (w_hist_match[k])
        );
    end

    // run cells, cell 0 drives the output
    for (genvar k = 0; k < RD; k++) begin : g_run
        if (k == RD - 1) begin : g_tail
            assign w_next[k] = '0;
        end else begin : g_body
            assign w_next[k] = w_slot[k + 1];
        end
        gsc_run_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_in_acc),
            .i_load_slot (w_load[k]),
            .i_shift     (w_out_acc),
            .i_next_slot (w_next[k]),
            .o_slot      (w_slot[k])
        );
    end

    assign w_header  = (&w_hist_match) && (i_data_byte == gsc_pkg::BYTE_LOW_A);
    assign w_trailer = (w_hist[0] == gsc_pkg::BYTE_NUL)
                    && (i_data_byte == gsc_pkg::BYTE_TRAILER);
    assign w_count_inc = (&r_byte_count) ? r_byte_count
                                          : r_byte_count + {{(gsc_pkg::COUNT_W-1){1'b0}}, 1'b1};
    assign w_force = (w_count_inc > r_max_size) || i_end_of_stream;

    always_comb begin
        for (int k = 0; k < RD; k++) begin
            w_load[k] = '0;
        end
        w_hist_clear   = 1'b0;
        w_hist_shift   = 1'b0;
        n_carving      = r_carving;
        n_byte_count   = r_byte_count;
        n_file_counter = r_file_counter;
        n_file_number  = r_file_number;

        if (w_in_acc) begin
            if (!r_carving) begin
                if (w_header) begin
                    for (int k = 0; k < RD - 1; k++) begin
                        w_load[k].valid = 1'b1;
                        w_load[k].data  = w_hist[HD - 1 - k];
                    end
                    w_load[RD-1].valid      = 1'b1;
                    w_load[RD-1].data       = i_data_byte;
                    w_load[RD-1].last       = 1'b1;
                    w_load[RD-1].file_end   = i_end_of_stream;
                    w_load[RD-1].forced_end = i_end_of_stream;
                    n_file_number  = r_file_counter;
                    n_file_counter = r_file_counter + {{(gsc_pkg::FNUM_W-1){1'b0}}, 1'b1};
                    if (i_end_of_stream) begin
                        w_hist_clear = 1'b1;
                    end else begin
                        w_hist_shift = 1'b1;
                        n_carving    = 1'b1;
                        n_byte_count = gsc_pkg::HEADER_LEN;
                    end
                end else if (i_end_of_stream) begin
                    w_hist_clear = 1'b1;
                end else begin
                    w_hist_shift = 1'b1;
                end
            end else begin
                w_load[0].valid = 1'b1;
                w_load[0].data  = i_data_byte;
                if (w_trailer) begin
                    w_load[0].last     = 1'b1;
                    w_load[0].file_end = 1'b1;
                    w_hist_clear = 1'b1;
                    n_carving    = 1'b0;
                    n_byte_count = '0;
                end else if (w_force) begin
                    w_load[1].valid      = 1'b1;
                    w_load[1].data       = gsc_pkg::BYTE_NUL;
                    w_load[2].valid      = 1'b1;
                    w_load[2].data       = gsc_pkg::BYTE_TRAILER;
                    w_load[2].last       = 1'b1;
                    w_load[2].file_end   = 1'b1;
                    w_load[2].forced_end = 1'b1;
                    w_hist_clear = 1'b1;
                    n_carving    = 1'b0;
                    n_byte_count = '0;
                end else begin
                    w_load[0].last = 1'b1;
                    w_hist_shift = 1'b1;
                    n_byte_count = w_count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size     <= gsc_pkg::MAX_SIZE_RESET;
            r_carving      <= 1'b0;
            r_byte_count   <= '0;
            r_file_counter <= gsc_pkg::FIRST_FILE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_size <= i_cfg_max_size;
            end
            r_carving      <= n_carving;
            r_byte_count   <= n_byte_count;
            r_file_counter <= n_file_counter;
        end
    end

    // file number of the run in the cells; during carving it is the last one issued
    always_ff @(posedge i_clk) begin
        r_file_number <= n_file_number;
    end

    assign o_valid       = w_slot[0].valid;
    assign o_out_byte    = w_slot[0].data;
    assign o_file_number = r_file_number;
    assign o_file_end    = w_slot[0].file_end;
    assign o_forced_end  = w_slot[0].forced_end;
    assign o_last_of_run = w_slot[0].last;

    `GSC_ASSERT_SAME(a_last_alone, i_clk, i_rst_n, o_valid && o_last_of_run, !w_slot[1].valid)
    `GSC_ASSERT_NEXT(a_carve_emits, i_clk, i_rst_n, w_in_acc && r_carving, o_valid)
    `GSC_ASSERT_SAME(a_count_state, i_clk, i_rst_n, 1'b1,
        (r_carving && (r_byte_count >= gsc_pkg::HEADER_LEN))
        || (!r_carving && (r_byte_count == '0)))

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] HDR_87A     = "GIF87a";
    localparam logic [47:0] HDR_89A     = "GIF89a";
    localparam int          QUIET_LIMIT = 1000;
    localparam int          SETTLE      = 8;

    typedef struct packed {
        logic [7:0]                 data;
        logic [gsc_pkg::FNUM_W-1:0] file_num;
        logic                       file_end;
        logic                       forced_end;
        logic                       last_of_run;
    } t_carve_result;

    typedef enum int {CLOSE_TRAILER, CLOSE_EOS, CLOSE_PAUSE, CLOSE_NONE} t_close_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_stream;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic [15:0] o_file_number;
    logic        o_file_end;
    logic        o_forced_end;
    logic        o_last_of_run;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_max_size;

    // carving state of the predictor
    logic [39:0]                 scan_hist     = '0;
    logic                        in_file       = 1'b0;
    logic [gsc_pkg::COUNT_W-1:0] file_len      = '0;
    logic [gsc_pkg::FNUM_W-1:0]  next_file_num = gsc_pkg::FIRST_FILE;
    logic [gsc_pkg::COUNT_W-1:0] size_limit    = gsc_pkg::MAX_SIZE_RESET;

    t_carve_result carved_bytes_q[$];
    int            mismatch_count = 0;
    int            items_sent     = 0;
    int            quiet_cycles   = 0;
    int            tx_max_gap     = 6;
    int            rx_max_gap     = 6;
    int            rx_hold_len    = 0;

    gif_signature_carver_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_file_number   (o_file_number),
        .o_file_end      (o_file_end),
        .o_forced_end    (o_forced_end),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_size  (i_cfg_max_size)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    function automatic void push_carved(input logic [7:0] data,
                                        input logic [gsc_pkg::FNUM_W-1:0] num,
                                        input logic fend, input logic forced,
                                        input logic last);
        t_carve_result r;
        r.data        = data;
        r.file_num    = num;
        r.file_end    = fend;
        r.forced_end  = forced;
        r.last_of_run = last;
        carved_bytes_q.push_back(r);
    endfunction

    function automatic void close_file();
        in_file   = 1'b0;
        file_len  = '0;
        scan_hist = '0;
    endfunction

    function automatic void carve_byte(input logic [7:0] b, input logic eos);
        logic [47:0]                six;
        logic [gsc_pkg::FNUM_W-1:0] num;
        six = {scan_hist, b};
        if (!in_file) begin
            if (six == HDR_87A || six == HDR_89A) begin
                for (int k = 0; k < 6; k++)
                    push_carved(six[47-8*k -: 8], next_file_num, (k == 5) && eos,
                                (k == 5) && eos, k == 5);
                next_file_num++;
                if (eos) begin
                    scan_hist = '0;
                end else begin
                    in_file   = 1'b1;
                    file_len  = gsc_pkg::HEADER_LEN;
                    scan_hist = six[39:0];
                end
            end else begin
                scan_hist = eos ? '0 : six[39:0];
            end
            return;
        end
        num = next_file_num - 1'b1;
        // trailer wins over both the size limit and the stream end
        if (scan_hist[7:0] == gsc_pkg::BYTE_NUL && b == gsc_pkg::BYTE_TRAILER) begin
            push_carved(b, num, 1'b1, 1'b0, 1'b1);
            close_file();
        end else begin
            if (file_len != '1)
                file_len++;
            if (file_len > size_limit || eos) begin
                push_carved(b, num, 1'b0, 1'b0, 1'b0);
                push_carved(gsc_pkg::BYTE_NUL, num, 1'b0, 1'b0, 1'b0);
                push_carved(gsc_pkg::BYTE_TRAILER, num, 1'b1, 1'b1, 1'b1);
                close_file();
            end else begin
                push_carved(b, num, 1'b0, 1'b0, 1'b1);
                scan_hist = six[39:0];
            end
        end
    endfunction

    task automatic check_result();
        t_carve_result want;
        if (carved_bytes_q.size() == 0) begin
            report_mismatch($sformatf("byte %02h of file %0d with no request pending",
                                      o_out_byte, o_file_number));
            return;
        end
        want = carved_bytes_q.pop_front();
        if (o_out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", o_out_byte, want.data));
        if (o_file_number !== want.file_num)
            report_mismatch($sformatf("file_number %0d, want %0d",
                                      o_file_number, want.file_num));
        if (o_file_end !== want.file_end)
            report_mismatch($sformatf("file_end %b, want %b", o_file_end, want.file_end));
        if (o_forced_end !== want.forced_end)
            report_mismatch($sformatf("forced_end %b, want %b",
                                      o_forced_end, want.forced_end));
        if (o_last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b",
                                      o_last_of_run, want.last_of_run));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_hist     = '0;
            in_file       = 1'b0;
            file_len      = '0;
            next_file_num = gsc_pkg::FIRST_FILE;
            size_limit    = gsc_pkg::MAX_SIZE_RESET;
            quiet_cycles++;
        end else begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (o_valid && !i_stall)
                check_result();
            if (i_valid && !o_stall)
                carve_byte(i_data_byte, i_end_of_stream);
            if (i_cfg_valid && o_cfg_ready)
                size_limit = i_cfg_max_size;
        end
    end

    // result side: random stall per result, or one long hold when asked
    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        forever begin
            if (rx_hold_len > 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                hold = $urandom_range(0, rx_max_gap);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] data, input logic eos);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= data;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_header(input logic alt, input logic eos_last);
        logic [47:0] hdr;
        hdr = alt ? HDR_89A : HDR_87A;
        for (int k = 0; k < 6; k++)
            send_byte(hdr[47-8*k -: 8], eos_last && (k == 5));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (carved_bytes_q.size() != 0) @(posedge i_clk);
        // a byte with no result may still be in flight
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_size(input logic [gsc_pkg::COUNT_W-1:0] limit);
        drain_results();
        i_cfg_valid    <= 1'b1;
        i_cfg_max_size <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        send_byte(8'hFF, 1'b0);
        send_header(1'b0, 1'b0);
        send_byte(gsc_pkg::BYTE_NUL, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(gsc_pkg::BYTE_TRAILER, 1'b0);
        // stream ends inside a file whose tail looks like a header
        send_header(1'b1, 1'b0);
        for (int k = 0; k < 5; k++)
            send_byte(HDR_87A[47-8*k -: 8], k == 4);
        // history was cleared, so this must not complete a header
        send_byte("a", 1'b1);
        send_header(1'b1, 1'b1);
    endtask

    task automatic test_size_limit_priority();
        write_max_size(20'd7);
        send_header(1'b1, 1'b0);
        send_byte(gsc_pkg::BYTE_NUL, 1'b0);
        send_byte(gsc_pkg::BYTE_TRAILER, 1'b1);
        send_header(1'b0, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
    endtask

    task automatic test_output_backpressure();
        tx_max_gap  = 0;
        rx_max_gap  = 0;
        rx_hold_len = 150;
        for (int k = 0; k < 4; k++)
            send_header(k[0], 1'b1);
        send_header(1'b0, 1'b0);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(gsc_pkg::BYTE_NUL, 1'b0);
        send_byte(gsc_pkg::BYTE_TRAILER, 1'b0);
        drain_results();
        tx_max_gap = 6;
        rx_max_gap = 6;
    endtask

    task automatic test_random_streams();
        logic [gsc_pkg::COUNT_W-1:0] limits [5];
        logic [47:0]                 hdr;
        logic [7:0]                  body;
        logic                        hdr_eos;
        int                          stop_at;
        int                          pos;
        int                          len;
        limits[0] = 20'd6;
        limits[1] = 20'($urandom_range(8, 60));
        limits[2] = '0;
        limits[3] = gsc_pkg::MAX_SIZE_RESET;
        limits[4] = '1;
        for (int p = 0; p < 5; p++) begin
            write_max_size(limits[p]);
            stop_at = items_sent + 30;
            while (items_sent < stop_at) begin
                tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
                rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                hdr = $urandom_range(0, 1) ? HDR_89A : HDR_87A;
                // now and then a flipped header bit or a stream end inside the header
                pos = $urandom_range(0, 5);
                if ($urandom_range(0, 7) == 0)
                    hdr[47-8*pos -: 8] ^= 8'(1 << $urandom_range(0, 7));
                hdr_eos = $urandom_range(0, 9) == 0;
                for (int k = 0; k < 6; k++)
                    send_byte(hdr[47-8*k -: 8], hdr_eos && (k == pos));
                len = $urandom_range(0, 12);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 7))
                        0: body = gsc_pkg::BYTE_NUL;
                        1: body = gsc_pkg::BYTE_TRAILER;
                        default: body = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(body, 1'b0);
                end
                case (t_close_kind'($urandom_range(0, 3)))
                    CLOSE_TRAILER: begin
                        send_byte(gsc_pkg::BYTE_NUL, 1'b0);
                        send_byte(gsc_pkg::BYTE_TRAILER, 1'b0);
                    end
                    CLOSE_EOS: send_byte(8'($urandom_range(0, 255)), 1'b1);
                    CLOSE_PAUSE: drain_results();
                    default: ;
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_data_byte     <= '0;
        i_end_of_stream <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_max_size  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_size_limit_priority();
        test_output_backpressure();
        test_random_streams();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (carved_bytes_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", carved_bytes_q.size()));
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
